// ----- hdl/pbsc_pkg.sv -----
// Package for the pixel background sample classifier.
// Holds request/result payload types, config register indexes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package pbsc_pkg;

	typedef struct packed {
		logic        kind;
		logic [7:0]  pixel_row;
		logic [7:0]  pixel_col;
		logic [4:0]  load_slot;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] draw_self_gate;
		logic [15:0] draw_self_slot;
		logic [15:0] draw_nbr_gate;
		logic [2:0]  draw_nbr_which;
		logic [15:0] draw_nbr_slot;
	} req_t;

	typedef struct packed {
		logic       foreground;
		logic [5:0] match_count;
		logic       was_load;
	} res_t;

	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MODEL_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODEL_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SAMPLES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_MATCHES  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUBSAMPLE    = 3'd5;

	localparam logic KIND_LOAD = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD,
		ST_READ,
		ST_DECIDE,
		ST_WSELF,
		ST_WNBR,
		ST_DONE
	} state_t;

endpackage

// ----- hdl/pbsc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module pbsc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/pixel_background_sample_classifier.sv -----
// Pixel background sample classifier: per-pixel sample store in one synchronous RAM.
// A load request, or a classify request outside the model, goes from ST_MOD straight to
// ST_DONE. A classify request first runs a 16-step remainder unit, then reads one sample
// per cycle from the single RAM read port, up to the effective sample count; reading stops
// early once min_matches samples match. A foreground pixel then goes from ST_DECIDE to
// ST_DONE; a background pixel first passes the write-back states ST_WSELF and ST_WNBR.
// The result is registered in ST_DONE. One request is in work at a time; the block is ready
// for the next one in the cycle after the result is registered. Reset (arst_n low) clears the control
// state and loads the config defaults; the sample store is undefined until loaded.
`timescale 1ns / 1ps
module pixel_background_sample_classifier #(
	parameter int MAX_SAMPLES = 32,
	parameter int MAX_COLS    = 256,
	parameter int MAX_ROWS    = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  pbsc_pkg::req_t                   in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pbsc_pkg::res_t                   out_data,
	input  logic                             cfg_we,
	input  logic [pbsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pbsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// Address layout: row, column, slot concatenated.
	localparam int SW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int AW = RW + CW + SW;
	localparam int DEPTH = MAX_ROWS * MAX_COLS * (2 ** SW);
	// Counters that must hold the effective sample count itself (up to MAX_SAMPLES).
	localparam int NW = $clog2(MAX_SAMPLES + 1);

	// Configuration registers.
	logic [8:0] model_width_q, model_height_q, radius_q, subsample_q;
	logic [5:0] num_samples_q, min_matches_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_width_q  <= 9'd256;
			model_height_q <= 9'd256;
			num_samples_q  <= 6'd20;
			radius_q       <= 9'd20;
			min_matches_q  <= 6'd2;
			subsample_q    <= 9'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				pbsc_pkg::REG_MODEL_WIDTH:  model_width_q  <= cfg_data;
				pbsc_pkg::REG_MODEL_HEIGHT: model_height_q <= cfg_data;
				pbsc_pkg::REG_NUM_SAMPLES:  num_samples_q  <= cfg_data[5:0];
				pbsc_pkg::REG_RADIUS:       radius_q       <= cfg_data;
				pbsc_pkg::REG_MIN_MATCHES:  min_matches_q  <= cfg_data[5:0];
				pbsc_pkg::REG_SUBSAMPLE:    subsample_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective sizes with the caps and zero-as-one rules applied.
	logic [12:0] eff_w, eff_h;
	logic [6:0]  eff_n;
	logic [8:0]  eff_sub;
	always_comb begin
		eff_w = (13'(model_width_q) > 13'(MAX_COLS)) ? 13'(MAX_COLS) : 13'(model_width_q);
		eff_h = (13'(model_height_q) > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : 13'(model_height_q);
		if (num_samples_q == 6'd0) begin
			eff_n = 7'd1;
		end else if (7'(num_samples_q) > 7'(MAX_SAMPLES)) begin
			eff_n = 7'(MAX_SAMPLES);
		end else begin
			eff_n = 7'(num_samples_q);
		end
		eff_sub = (subsample_q == 9'd0) ? 9'd1 : subsample_q;
	end

	// Request and per-request working registers.
	pbsc_pkg::req_t  req_q;
	pbsc_pkg::state_t state_q, state_d;
	pbsc_pkg::res_t  res_q;
	logic            out_valid_q;

	logic [17:0] r2_q;          // radius squared
	logic [NW-1:0] slot_q;      // read slot counter
	logic [5:0]  count_q;
	logic        rd_pend_s1;    // a read was issued last cycle
	logic        mod_busy;

	// Four restoring dividers share one 16-step sequence: remainders of the gate
	// draws by the subsample factor and of the slot draws by the sample count.
	logic [15:0] q_sg_q, q_ss_q, q_ng_q, q_ns_q;
	logic [9:0]  r_sg_q, r_ss_q, r_ng_q, r_ns_q;
	logic [4:0]  step_q;

	function automatic logic [9:0] rstep(input logic [9:0] r, input logic b, input logic [9:0] d);
		logic [10:0] t;
		t = {r, b};
		if (t >= 11'(d)) begin
			t = t - 11'(d);
		end
		return t[9:0];
	endfunction

	// Pixel inside the model and on the interior for neighbor updates.
	logic in_model, interior;
	always_comb begin
		in_model = (13'(req_q.pixel_row) < eff_h) && (13'(req_q.pixel_col) < eff_w);
		interior = (req_q.pixel_row != 8'd0) && (13'(req_q.pixel_row) + 13'd1 != eff_h)
			&& (req_q.pixel_col != 8'd0) && (13'(req_q.pixel_col) + 13'd1 != eff_w);
	end

	// Distance of the sample read back against the request pixel.
	logic [23:0] rdata;
	logic [8:0]  dr, dg, db;
	logic [17:0] d2;
	logic        match;
	always_comb begin
		dr = 9'(req_q.red)   - 9'(rdata[7:0]);
		dg = 9'(req_q.green) - 9'(rdata[15:8]);
		db = 9'(req_q.blue)  - 9'(rdata[23:16]);
		dr = dr[8] ? -dr : dr;
		dg = dg[8] ? -dg : dg;
		db = db[8] ? -db : db;
		d2 = 18'(16'(dr[7:0]) * 16'(dr[7:0])) + 18'(16'(dg[7:0]) * 16'(dg[7:0]))
			+ 18'(16'(db[7:0]) * 16'(db[7:0]));
		match = (d2 <= r2_q);
	end

	// Neighbor coordinates.
	logic [7:0] nrow, ncol;
	always_comb begin
		nrow = req_q.pixel_row;
		ncol = req_q.pixel_col;
		case (req_q.draw_nbr_which)
			3'd0: begin nrow = nrow - 8'd1; ncol = ncol - 8'd1; end
			3'd1: nrow = nrow - 8'd1;
			3'd2: begin nrow = nrow - 8'd1; ncol = ncol + 8'd1; end
			3'd3: ncol = ncol + 8'd1;
			3'd4: ncol = ncol - 8'd1;
			3'd5: begin nrow = nrow + 8'd1; ncol = ncol - 8'd1; end
			3'd6: nrow = nrow + 8'd1;
			default: begin nrow = nrow + 8'd1; ncol = ncol + 8'd1; end
		endcase
	end

	function automatic logic [AW-1:0] addr_of(input logic [7:0] r, input logic [7:0] c,
			input logic [9:0] s);
		return {RW'(r), CW'(c), s[SW-1:0]};
	endfunction

	logic [5:0] count_next;
	assign count_next = (rd_pend_s1 && match && count_q != min_matches_q)
		? count_q + 6'd1 : count_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pbsc_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = pbsc_pkg::ST_MOD;
				end
			end
			pbsc_pkg::ST_MOD: begin
				if (req_q.kind == pbsc_pkg::KIND_LOAD || !in_model) begin
					state_d = pbsc_pkg::ST_DONE;
				end else if (!mod_busy) begin
					state_d = pbsc_pkg::ST_READ;
				end
			end
			pbsc_pkg::ST_READ: begin
				if (count_next == min_matches_q
					|| ((7'(slot_q) >= eff_n) && !rd_pend_s1)) begin
					state_d = pbsc_pkg::ST_DECIDE;
				end
			end
			pbsc_pkg::ST_DECIDE: begin
				if (count_q != min_matches_q) begin
					state_d = pbsc_pkg::ST_DONE;
				end else begin
					state_d = pbsc_pkg::ST_WSELF;
				end
			end
			pbsc_pkg::ST_WSELF: state_d = pbsc_pkg::ST_WNBR;
			pbsc_pkg::ST_WNBR:  state_d = pbsc_pkg::ST_DONE;
			pbsc_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = pbsc_pkg::ST_IDLE;
				end
			end
			default: state_d = pbsc_pkg::ST_IDLE;
		endcase
	end

	// RAM port controls.
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic          rd_issue;
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_of(req_q.pixel_row, req_q.pixel_col, 10'(req_q.load_slot));
		rd_issue  = 1'b0;
		ram_raddr = addr_of(req_q.pixel_row, req_q.pixel_col, 10'(slot_q));
		in_ready  = (state_q == pbsc_pkg::ST_IDLE);
		case (state_q)
			pbsc_pkg::ST_MOD: begin
				ram_we = (req_q.kind == pbsc_pkg::KIND_LOAD) && in_model
					&& (7'(req_q.load_slot) < 7'(MAX_SAMPLES));
			end
			pbsc_pkg::ST_READ: begin
				rd_issue = (7'(slot_q) < eff_n) && (count_next != min_matches_q);
			end
			pbsc_pkg::ST_WSELF: begin
				ram_we    = (r_sg_q == 10'd0);
				ram_waddr = addr_of(req_q.pixel_row, req_q.pixel_col, r_ss_q);
			end
			pbsc_pkg::ST_WNBR: begin
				ram_we    = interior && (r_ng_q == 10'd0);
				ram_waddr = addr_of(nrow, ncol, r_ns_q);
			end
			default: ;
		endcase
	end

	pbsc_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({req_q.blue, req_q.green, req_q.red}),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	assign mod_busy = (step_q != 5'd0);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pbsc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= 5'd0;
			rd_pend_s1  <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= rd_issue;
			if (state_q == pbsc_pkg::ST_IDLE && in_valid) begin
				step_q <= 5'd16;
			end else if (mod_busy) begin
				step_q <= step_q - 5'd1;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == pbsc_pkg::ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == pbsc_pkg::ST_IDLE && in_valid) begin
			req_q   <= in_data;
			r2_q    <= 18'(radius_q) * 18'(radius_q);
			slot_q  <= '0;
			count_q <= 6'd0;
			q_sg_q  <= in_data.draw_self_gate;
			q_ss_q  <= in_data.draw_self_slot;
			q_ng_q  <= in_data.draw_nbr_gate;
			q_ns_q  <= in_data.draw_nbr_slot;
			r_sg_q  <= '0;
			r_ss_q  <= '0;
			r_ng_q  <= '0;
			r_ns_q  <= '0;
		end else begin
			if (mod_busy) begin
				r_sg_q <= rstep(r_sg_q, q_sg_q[15], 10'(eff_sub));
				r_ss_q <= rstep(r_ss_q, q_ss_q[15], 10'(eff_n));
				r_ng_q <= rstep(r_ng_q, q_ng_q[15], 10'(eff_sub));
				r_ns_q <= rstep(r_ns_q, q_ns_q[15], 10'(eff_n));
				q_sg_q <= {q_sg_q[14:0], 1'b0};
				q_ss_q <= {q_ss_q[14:0], 1'b0};
				q_ng_q <= {q_ng_q[14:0], 1'b0};
				q_ns_q <= {q_ns_q[14:0], 1'b0};
			end
			if (state_q == pbsc_pkg::ST_READ) begin
				count_q <= count_next;
				if (rd_issue) begin
					slot_q <= slot_q + NW'(1);
				end
			end
		end
		if (state_q == pbsc_pkg::ST_DONE && (!out_valid_q || out_ready)) begin
			if (req_q.kind == pbsc_pkg::KIND_LOAD) begin
				res_q <= '{foreground: 1'b0, match_count: 6'd0, was_load: 1'b1};
			end else if (!in_model) begin
				res_q <= '{foreground: 1'b1, match_count: 6'd0, was_load: 1'b0};
			end else begin
				res_q <= '{foreground: (count_q != min_matches_q), match_count: count_q,
					was_load: 1'b0};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = res_q;

endmodule

// ----- tb/tb_pixel_background_sample_classifier.sv -----
// Testbench for pixel_background_sample_classifier: random and directed requests checked
// against a behavioral model of the sample store, held in a small scoreboard class.
// Depends on hdl/pbsc_pkg.sv, hdl/pixel_background_sample_classifier.sv and, through it, hdl/pbsc_ram.sv.
`timescale 1ns / 1ps
module tb_pixel_background_sample_classifier;

	localparam int N_SLOTS = 32;
	localparam int N_COLS = 256;
	localparam int N_ROWS = 256;
	localparam int STALL_LIMIT = 5000;
	localparam int DW = pbsc_pkg::CFG_DATA_W;
	localparam int IW = pbsc_pkg::CFG_IDX_W;

	// Scoreboard: a shadow copy of the sample store and the registers, and the queue
	// of results that accepted requests are expected to produce, in order.
	class sample_scoreboard;
		logic [23:0] shadow_store [int unsigned];
		int unsigned width_reg, height_reg, samples_reg, radius_reg, min_reg, sub_reg;
		pbsc_pkg::res_t pending_results [$];
		int mismatches;

		function new();
			width_reg = 256;
			height_reg = 256;
			samples_reg = 20;
			radius_reg = 20;
			min_reg = 2;
			sub_reg = 16;
			mismatches = 0;
		endfunction

		function void write_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
			case (idx)
				pbsc_pkg::REG_MODEL_WIDTH:  width_reg = 32'(val);
				pbsc_pkg::REG_MODEL_HEIGHT: height_reg = 32'(val);
				pbsc_pkg::REG_NUM_SAMPLES:  samples_reg = 32'(val[5:0]);
				pbsc_pkg::REG_RADIUS:       radius_reg = 32'(val);
				pbsc_pkg::REG_MIN_MATCHES:  min_reg = 32'(val[5:0]);
				pbsc_pkg::REG_SUBSAMPLE:    sub_reg = 32'(val);
				default: ;
			endcase
		endfunction

		function int unsigned slot_index(int unsigned row, int unsigned col, int unsigned slot);
			return (row * N_COLS + col) * N_SLOTS + slot;
		endfunction

		function void add_result(pbsc_pkg::res_t x);
			pending_results = {pending_results, x};
		endfunction

		// Works out the result of one accepted request and applies its store updates.
		function void note_request(pbsc_pkg::req_t r);
			int unsigned w, h, n, sub, cnt, r2, d2, k, nr, nc;
			int dr [8];
			int dc [8];
			int d;
			logic [23:0] pix, s;
			bit in_model;
			dr = '{-1, -1, -1, 0, 0, 1, 1, 1};
			dc = '{-1, 0, 1, 1, -1, -1, 0, 1};
			w = (width_reg > N_COLS) ? N_COLS : width_reg;
			h = (height_reg > N_ROWS) ? N_ROWS : height_reg;
			n = (samples_reg == 0) ? 1 : ((samples_reg > N_SLOTS) ? N_SLOTS : samples_reg);
			sub = (sub_reg == 0) ? 1 : sub_reg;
			pix = {r.blue, r.green, r.red};
			in_model = (r.pixel_row < h) && (r.pixel_col < w);
			if (r.kind == pbsc_pkg::KIND_LOAD) begin
				if (in_model && r.load_slot < N_SLOTS)
					shadow_store[slot_index(r.pixel_row, r.pixel_col, r.load_slot)] = pix;
				add_result('{1'b0, 6'd0, 1'b1});
				return;
			end
			if (!in_model) begin
				add_result('{1'b1, 6'd0, 1'b0});
				return;
			end
			r2 = radius_reg * radius_reg;
			cnt = 0;
			for (k = 0; k < n && cnt < min_reg; k++) begin
				s = shadow_store.exists(slot_index(r.pixel_row, r.pixel_col, k)) ?
					shadow_store[slot_index(r.pixel_row, r.pixel_col, k)] : 24'd0;
				d2 = 0;
				for (int c = 0; c < 3; c++) begin
					d = int'(s[c*8 +: 8]) - int'(pix[c*8 +: 8]);
					d2 += d * d;
				end
				if (d2 <= r2)
					cnt++;
			end
			if (cnt != min_reg) begin
				add_result('{1'b1, cnt[5:0], 1'b0});
				return;
			end
			if (r.draw_self_gate % sub == 0)
				shadow_store[slot_index(r.pixel_row, r.pixel_col, r.draw_self_slot % n)] = pix;
			if (r.pixel_row != 0 && r.pixel_row + 1 != h && r.pixel_col != 0 &&
					r.pixel_col + 1 != w && r.draw_nbr_gate % sub == 0) begin
				nr = int'(r.pixel_row) + dr[r.draw_nbr_which];
				nc = int'(r.pixel_col) + dc[r.draw_nbr_which];
				shadow_store[slot_index(nr, nc, r.draw_nbr_slot % n)] = pix;
			end
			add_result('{1'b0, cnt[5:0], 1'b0});
		endfunction

		function void check_result(pbsc_pkg::res_t got);
			pbsc_pkg::res_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result fg=%0d count=%0d load=%0d",
						got.foreground, got.match_count, got.was_load);
				return;
			end
			want = pending_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result fg=%0d count=%0d load=%0d, expected %0d %0d %0d",
						got.foreground, got.match_count, got.was_load,
						want.foreground, want.match_count, want.was_load);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	pbsc_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pbsc_pkg::res_t out_data;
	logic cfg_we = 1'b0;
	logic [IW-1:0] cfg_index = '0;
	logic [DW-1:0] cfg_data = '0;

	sample_scoreboard sb = new();

	// Stimulus-side view of the configuration and of which slots hold a loaded sample.
	// Only loads are tracked, so this is a conservative subset of the written slots.
	bit loaded_slot [int unsigned];
	int unsigned eff_w, eff_h, eff_n, cur_sub;
	logic [23:0] base_color;
	int hold_requests = 0;
	int idle_cycles = 0;

	always #6 clk = ~clk;

	pixel_background_sample_classifier dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Both handshakes are observed at the rising edge. The watchdog ends the run when
	// nothing moves for far longer than the slowest request plus the longest stall.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_request(in_data);
		if (out_valid && out_ready)
			sb.check_result(out_data);
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver: bursts of ready with random gaps, mostly short. When the stimulus asks
	// for it, ready stays low for a long stretch so the block backs up into its input.
	initial begin
		int burst, gap, pick, holds_done;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			burst = $urandom_range(1, 24);
			repeat (burst) @(negedge clk) out_ready <= 1'b1;
			pick = $urandom_range(0, 99);
			if (holds_done < hold_requests) begin
				holds_done++;
				gap = 400;
			end else if (pick < 40)
				gap = 0;
			else if (pick < 90)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(10, 60);
			repeat (gap) @(negedge clk) out_ready <= 1'b0;
		end
	end

	function automatic int random_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	// Sends one request. A nonzero gap first lowers valid and waits out the gap; with no gap,
	// valid simply stays high into the next request.
	task automatic send_request(pbsc_pkg::req_t r, int gap);
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk) in_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// All six registers are written back to back while the block is idle.
	task automatic configure(int unsigned w, int unsigned h, int unsigned n, int unsigned rad,
			int unsigned mm, int unsigned sub);
		logic [DW-1:0] vals [6];
		logic [IW-1:0] idxs [6];
		vals = '{DW'(w), DW'(h), DW'(n), DW'(rad), DW'(mm), DW'(sub)};
		idxs = '{pbsc_pkg::REG_MODEL_WIDTH, pbsc_pkg::REG_MODEL_HEIGHT,
			pbsc_pkg::REG_NUM_SAMPLES, pbsc_pkg::REG_RADIUS,
			pbsc_pkg::REG_MIN_MATCHES, pbsc_pkg::REG_SUBSAMPLE};
		for (int i = 0; i < 6; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data <= vals[i];
			sb.write_reg(idxs[i], vals[i]);
		end
		@(negedge clk) cfg_we <= 1'b0;
		eff_w = (w > N_COLS) ? N_COLS : w;
		eff_h = (h > N_ROWS) ? N_ROWS : h;
		eff_n = (n[5:0] == 0) ? 1 : ((n[5:0] > N_SLOTS) ? N_SLOTS : 32'(n[5:0]));
		cur_sub = (sub == 0) ? 1 : sub;
	endtask

	function automatic logic [23:0] near_color(int spread);
		logic [23:0] c;
		int v;
		for (int i = 0; i < 3; i++) begin
			v = int'(base_color[i*8 +: 8]) + $urandom_range(0, 2 * spread) - spread;
			c[i*8 +: 8] = (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : v[7:0]);
		end
		return c;
	endfunction

	function automatic pbsc_pkg::req_t blank_request(bit is_load, int unsigned row,
			int unsigned col, logic [23:0] rgb);
		pbsc_pkg::req_t r;
		r = '{default: '0};
		r.kind = is_load ? pbsc_pkg::KIND_LOAD : ~pbsc_pkg::KIND_LOAD;
		r.pixel_row = 8'(row);
		r.pixel_col = 8'(col);
		{r.blue, r.green, r.red} = rgb;
		return r;
	endfunction

	task automatic load_sample(int unsigned row, int unsigned col, int unsigned slot,
			logic [23:0] rgb);
		pbsc_pkg::req_t r;
		r = blank_request(1'b1, row, col, rgb);
		r.load_slot = 5'(slot);
		r.draw_self_gate = 16'($urandom_range(0, 65535));
		r.draw_nbr_slot = 16'($urandom_range(0, 65535));
		send_request(r, random_gap());
		if (row < eff_h && col < eff_w)
			loaded_slot[sb.slot_index(row, col, slot)] = 1'b1;
	endtask

	function automatic logic [15:0] gate_draw();
		logic [15:0] g;
		g = 16'($urandom_range(0, 65535));
		if ($urandom_range(0, 1))
			g = g - 16'(g % cur_sub);
		return g;
	endfunction

	// Classifies a pixel. Inside the model, any checked slot that was never loaded is
	// loaded first so the block never reads an undefined sample.
	task automatic classify_pixel(int unsigned row, int unsigned col, logic [23:0] rgb);
		pbsc_pkg::req_t r;
		if (row < eff_h && col < eff_w)
			for (int k = 0; k < eff_n; k++)
				if (!loaded_slot.exists(sb.slot_index(row, col, k)))
					load_sample(row, col, k, near_color(12));
		r = blank_request(1'b0, row, col, rgb);
		r.load_slot = 5'($urandom_range(0, 31));
		r.draw_self_gate = gate_draw();
		r.draw_self_slot = 16'($urandom_range(0, 65535));
		r.draw_nbr_gate = gate_draw();
		r.draw_nbr_which = 3'($urandom_range(0, 7));
		r.draw_nbr_slot = 16'($urandom_range(0, 65535));
		send_request(r, random_gap());
	endtask

	// One phase of traffic: a small pool of pixels, corners included, gets mostly
	// classify requests near a base color, with loads, far colors and outside pixels.
	task automatic run_phase(int requests);
		int unsigned rows [6];
		int unsigned cols [6];
		int unsigned p, pick, row, col;
		base_color = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255))};
		rows = '{0, eff_h - 1, eff_h - 1, 0, $urandom_range(0, eff_h - 1),
			$urandom_range(0, eff_h - 1)};
		cols = '{0, eff_w - 1, 0, eff_w - 1, $urandom_range(0, eff_w - 1),
			$urandom_range(0, eff_w - 1)};
		if (eff_h > 2 && eff_w > 2) begin
			rows[4] = $urandom_range(1, eff_h - 2);
			cols[4] = $urandom_range(1, eff_w - 2);
		end
		for (int i = 0; i < requests; i++) begin
			p = $urandom_range(0, 5);
			pick = $urandom_range(0, 99);
			if (pick < 8 && (eff_h < N_ROWS || eff_w < N_COLS)) begin
				// A pixel outside the model: nothing is read or written.
				if (eff_w < N_COLS) begin
					row = $urandom_range(0, 255);
					col = $urandom_range(eff_w, 255);
				end else begin
					row = $urandom_range(eff_h, 255);
					col = $urandom_range(0, 255);
				end
				if ($urandom_range(0, 1))
					load_sample(row, col, $urandom_range(0, 31), near_color(255));
				else
					classify_pixel(row, col, near_color(255));
			end else if (pick < 20)
				load_sample(rows[p], cols[p], $urandom_range(0, 31), near_color(20));
			else if (pick < 30)
				classify_pixel(rows[p], cols[p], near_color(255));
			else
				classify_pixel(rows[p], cols[p], near_color($urandom_range(0, 30)));
		end
		wait_drained();
	endtask

	initial begin
		eff_w = 256;
		eff_h = 256;
		eff_n = 20;
		cur_sub = 16;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed settings: reset defaults first, then the register extremes, the
		// above-limit and zero values, unreachable and zero match thresholds.
		run_phase(20);
		configure(8, 8, 4, 30, 2, 2);
		hold_requests++;
		run_phase(60);
		configure(256, 256, 32, 442, 32, 1);
		run_phase(25);
		configure(1, 1, 1, 0, 1, 256);
		run_phase(25);
		configure(300, 511, 0, 20, 0, 0);
		run_phase(25);
		configure(6, 5, 63, 60, 40, 3);
		run_phase(25);
		configure(3, 3, 8, 25, 3, 4);
		run_phase(40);

		// Random settings, kept small so most traffic reaches the update paths.
		for (int ph = 0; ph < 12; ph++) begin
			configure($urandom_range(1, 10), $urandom_range(1, 10), $urandom_range(1, 12),
				$urandom_range(0, 60), $urandom_range(0, 6), $urandom_range(1, 6));
			if (ph == 5)
				hold_requests++;
			run_phase(110);
		end

		wait_drained();
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/pbsc_pkg.sv
hdl/pbsc_ram.sv
hdl/pixel_background_sample_classifier.sv
tb/tb_pixel_background_sample_classifier.sv
